FILE: design/ray_box_slab_intersect_top_macros.svh
// Assertion macros shared by the ray/box slab intersection design.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RBSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RBSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rbsi_pkg.sv
`timescale 1ns / 1ps
package rbsi_pkg;

  localparam int FX_W          = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_AXES      = 3;
  localparam int NUM_STAGES    = 6;
  localparam int CFG_ADDR_W    = 3;
  localparam int IN_TDATA_W    = 192;
  localparam int OUT_TDATA_W   = 72;

  localparam logic signed [FX_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FX_W-1:0] FX_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } rbsi_reg_t;

  // Per-stage advance strobes of the shared pipeline.
  typedef struct packed {
    logic diff;
    logic prod;
    logic rnd;
    logic ord;
    logic mrg;
    logic outp;
  } rbsi_adv_t;

endpackage

FILE: design/rbsi_lane.sv
`timescale 1ns / 1ps
module rbsi_lane
  import rbsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  rbsi_adv_t              adv,
  input  logic signed [FX_W-1:0] box_lo,
  input  logic signed [FX_W-1:0] box_hi,
  input  logic signed [FX_W-1:0] origin,
  input  logic signed [FX_W-1:0] inv_dir,
  output logic signed [FX_W-1:0] t_near,
  output logic signed [FX_W-1:0] t_far
);

  localparam int DIFF_W = FX_W + 1;
  localparam int PROD_W = DIFF_W + FX_W;
  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(FX_MAX);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(FX_MIN);

  logic signed [DIFF_W-1:0] diff_lo_r, diff_hi_r;
  logic signed [FX_W-1:0]   inv_r;
  logic signed [PROD_W-1:0] prod_lo_r, prod_hi_r;
  logic signed [FX_W-1:0]   slab_lo_r, slab_hi_r;
  logic signed [FX_W-1:0]   slab_lo_nxt, slab_hi_nxt;
  logic signed [FX_W-1:0]   near_r, far_r;

  // Round half away from zero: negative products add one less than half.
  function automatic logic signed [FX_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] shr;
    sum = p + (p[PROD_W-1] ? HALF - PROD_W'(1) : HALF);
    shr = sum >>> FRAC_BITS;
    if (shr > SAT_HI) begin
      return FX_MAX;
    end else if (shr < SAT_LO) begin
      return FX_MIN;
    end
    return shr[FX_W-1:0];
  endfunction

  assign slab_lo_nxt = round_sat(prod_lo_r);
  assign slab_hi_nxt = round_sat(prod_hi_r);

  always_ff @(posedge clk) begin
    if (adv.diff) begin
      diff_lo_r <= DIFF_W'(box_lo) - DIFF_W'(origin);
      diff_hi_r <= DIFF_W'(box_hi) - DIFF_W'(origin);
      inv_r     <= inv_dir;
    end
    if (adv.prod) begin
      prod_lo_r <= PROD_W'(diff_lo_r) * PROD_W'(inv_r);
      prod_hi_r <= PROD_W'(diff_hi_r) * PROD_W'(inv_r);
    end
    if (adv.rnd) begin
      slab_lo_r <= slab_lo_nxt;
      slab_hi_r <= slab_hi_nxt;
    end
    if (adv.ord) begin
      near_r <= (slab_lo_r > slab_hi_r) ? slab_hi_r : slab_lo_r;
      far_r  <= (slab_lo_r > slab_hi_r) ? slab_lo_r : slab_hi_r;
    end
  end

  assign t_near = near_r;
  assign t_far  = far_r;

endmodule

FILE: design/rbsi_merge.sv
`timescale 1ns / 1ps
module rbsi_merge
  import rbsi_pkg::*;
(
  input  logic                   clk,
  input  rbsi_adv_t              adv,
  input  logic signed [FX_W-1:0] t_near [NUM_AXES],
  input  logic signed [FX_W-1:0] t_far  [NUM_AXES],
  output logic                   hit,
  output logic signed [FX_W-1:0] t_entry,
  output logic signed [FX_W-1:0] t_exit
);

  logic signed [FX_W-1:0] near01, far01;
  logic signed [FX_W-1:0] enter_nxt, leave_nxt;
  logic signed [FX_W-1:0] enter_r, leave_r;
  logic                   hit_nxt;
  logic                   hit_r;
  logic signed [FX_W-1:0] entry_r, exit_r;

  // Largest entry, smallest exit over the three axes.
  always_comb begin
    near01    = (t_near[0] > t_near[1]) ? t_near[0] : t_near[1];
    enter_nxt = (near01 > t_near[2]) ? near01 : t_near[2];
    far01     = (t_far[0] < t_far[1]) ? t_far[0] : t_far[1];
    leave_nxt = (far01 < t_far[2]) ? far01 : t_far[2];
  end

  // Miss when the interval is empty or lies wholly behind the origin.
  assign hit_nxt = !((enter_r > leave_r) || (enter_r[FX_W-1] && leave_r[FX_W-1]));

  always_ff @(posedge clk) begin
    if (adv.mrg) begin
      enter_r <= enter_nxt;
      leave_r <= leave_nxt;
    end
    if (adv.outp) begin
      hit_r   <= hit_nxt;
      entry_r <= hit_nxt ? enter_r : FX_MAX;
      exit_r  <= hit_nxt ? leave_r : FX_MAX;
    end
  end

  assign hit     = hit_r;
  assign t_entry = entry_r;
  assign t_exit  = exit_r;

endmodule

FILE: design/ray_box_slab_intersect_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// in_*      in   tvalid/tready      one ray: origin xyz, reciprocal direction xyz
// out_*     out  tvalid/tready      hit flag, entry distance, exit distance
// cfg_*     in   wr_en (no ready)   box bound register write
//
// Throughput: one ray per cycle while out_tready holds; six register stages.
// Depth is set by the per-axis lane pipeline (subtract, 33x32 multiply, round and
// saturate, order) followed by the merge stage and the output register.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// collapse and input is taken while a finished result waits at the output.
// Reset (rst_n low, synchronous) empties the pipeline and loads the empty box.
`include "ray_box_slab_intersect_top_macros.svh"
module ray_box_slab_intersect_top
  import rbsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input ray stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata, low bit up: origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata, low bit up: hit, t_entry, t_exit, 7 zero pad bits
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Box register writes.
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [FX_W-1:0]        cfg_wdata
);

  logic signed [FX_W-1:0] box_min_r [NUM_AXES];
  logic signed [FX_W-1:0] box_max_r [NUM_AXES];
  logic signed [FX_W-1:0] origin    [NUM_AXES];
  logic signed [FX_W-1:0] inv_dir   [NUM_AXES];
  logic signed [FX_W-1:0] t_near    [NUM_AXES];
  logic signed [FX_W-1:0] t_far     [NUM_AXES];

  logic [NUM_STAGES-1:0] valid_r, valid_nxt;
  logic [NUM_STAGES-1:0] adv_v;
  rbsi_adv_t             adv;

  logic                   hit;
  logic signed [FX_W-1:0] t_entry, t_exit;

  // Box registers; out-of-range indexes drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        box_min_r[k] <= FX_MAX;
        box_max_r[k] <= FX_MIN;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_BOX_MIN_X: box_min_r[0] <= cfg_wdata;
        REG_BOX_MIN_Y: box_min_r[1] <= cfg_wdata;
        REG_BOX_MIN_Z: box_min_r[2] <= cfg_wdata;
        REG_BOX_MAX_X: box_max_r[0] <= cfg_wdata;
        REG_BOX_MAX_Y: box_max_r[1] <= cfg_wdata;
        REG_BOX_MAX_Z: box_max_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the ray.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      origin[k]  = in_tdata[k*FX_W +: FX_W];
      inv_dir[k] = in_tdata[(k+NUM_AXES)*FX_W +: FX_W];
    end
  end

  // Advance strobes: a stage moves when empty or when its successor moves.
  always_comb begin
    adv_v[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv_v[k] = !valid_r[k] || adv_v[k+1];
    end
    valid_nxt[0] = adv_v[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = adv_v[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  assign adv = '{diff: adv_v[0], prod: adv_v[1], rnd: adv_v[2],
                 ord: adv_v[3], mrg: adv_v[4], outp: adv_v[5]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready = adv_v[0];

  // One lane per axis.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    rbsi_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .adv     (adv),
      .box_lo  (box_min_r[g]),
      .box_hi  (box_max_r[g]),
      .origin  (origin[g]),
      .inv_dir (inv_dir[g]),
      .t_near  (t_near[g]),
      .t_far   (t_far[g])
    );
  end

  rbsi_merge u_merge (
    .clk     (clk),
    .adv     (adv),
    .t_near  (t_near),
    .t_far   (t_far),
    .hit     (hit),
    .t_entry (t_entry),
    .t_exit  (t_exit)
  );

  assign out_tvalid = valid_r[NUM_STAGES-1];
  assign out_tdata  = {(OUT_TDATA_W - 2*FX_W - 1)'(0), t_exit, t_entry, hit};

  // A miss carries the saturated maximum in both distances.
  `RBSI_ASSERT_IMPL(a_miss_inf, clk, rst_n, out_tvalid && !out_tdata[0],
    (out_tdata[32:1] == FX_MAX) && (out_tdata[64:33] == FX_MAX), "miss without max distances")
  // A hit has an ordered interval.
  `RBSI_ASSERT_IMPL(a_hit_order, clk, rst_n, out_tvalid && out_tdata[0],
    $signed(out_tdata[32:1]) <= $signed(out_tdata[64:33]), "hit with entry after exit")
  // A hit never ends behind the origin.
  `RBSI_ASSERT_IMPL(a_hit_ahead, clk, rst_n, out_tvalid && out_tdata[0],
    !out_tdata[64], "hit with negative exit")
  // Input stalls only when every stage holds a ray.
  `RBSI_ASSERT_IMPL(a_no_bubble_stall, clk, rst_n, !in_tready,
    &valid_r, "input stalled with a bubble in the pipeline")
  // An accepted ray occupies the first stage.
  `RBSI_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_tvalid && in_tready,
    valid_r[0], "accepted ray lost at entry")

endmodule
